>>> rtl/core/hafcs_pkg.sv
package hafcs_pkg;

    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [7:0]  ESC_BYTE  = 8'h7D;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h8408;

    localparam int MAX_BEATS = 8;
    localparam int CNT_W     = $clog2(MAX_BEATS + 1);
    localparam int POS_W     = $clog2(MAX_BEATS);
    localparam int LIST_W    = MAX_BEATS * 8;

    typedef struct packed {
        logic              valid;
        logic [LIST_W-1:0] bytes;
        logic [CNT_W-1:0]  count;
        logic              frame_end;
    } load_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic logic needs_escape(input logic [7:0] b);
        return (b == FLAG_BYTE) || (b == ESC_BYTE);
    endfunction

endpackage

>>> rtl/core/hafcs_expand.sv
module hafcs_expand (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           data_byte,
    input  logic                 has_byte,
    input  logic                 last_byte,
    output hafcs_pkg::load_t     load
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        in_frame_reg;
    logic        in_frame_next;

    logic [15:0]                   crc_start;
    logic [15:0]                   crc_new;
    logic [15:0]                   fcs;
    logic [hafcs_pkg::LIST_W-1:0]  list;
    logic [hafcs_pkg::CNT_W-1:0]   n;
    logic                          active;

    assign active    = accept && (has_byte || last_byte);
    assign crc_start = in_frame_reg ? crc_reg : hafcs_pkg::CRC_INIT;
    assign crc_new   = has_byte ? hafcs_pkg::crc_byte(crc_start, data_byte) : crc_start;
    assign fcs       = ~crc_new;

    always_comb
    begin
        list = '0;
        n    = '0;
        if (!in_frame_reg)
        begin
            list[{n[hafcs_pkg::POS_W-1:0], 3'b000} +: 8] = hafcs_pkg::FLAG_BYTE;
            n = n + 1'b1;
        end
        if (has_byte)
        begin
            if (hafcs_pkg::needs_escape(data_byte))
            begin
                list[{n[hafcs_pkg::POS_W-1:0], 3'b000} +: 8] = hafcs_pkg::ESC_BYTE;
                n = n + 1'b1;
                list[{n[hafcs_pkg::POS_W-1:0], 3'b000} +: 8] = data_byte ^ hafcs_pkg::ESC_XOR;
            end
            else
            begin
                list[{n[hafcs_pkg::POS_W-1:0], 3'b000} +: 8] = data_byte;
            end
            n = n + 1'b1;
        end
        if (last_byte)
        begin
            if (hafcs_pkg::needs_escape(fcs[7:0]))
            begin
                list[{n[hafcs_pkg::POS_W-1:0], 3'b000} +: 8] = hafcs_pkg::ESC_BYTE;
                n = n + 1'b1;
                list[{n[hafcs_pkg::POS_W-1:0], 3'b000} +: 8] = fcs[7:0] ^ hafcs_pkg::ESC_XOR;
            end
            else
            begin
                list[{n[hafcs_pkg::POS_W-1:0], 3'b000} +: 8] = fcs[7:0];
            end
            n = n + 1'b1;
            if (hafcs_pkg::needs_escape(fcs[15:8]))
            begin
                list[{n[hafcs_pkg::POS_W-1:0], 3'b000} +: 8] = hafcs_pkg::ESC_BYTE;
                n = n + 1'b1;
                list[{n[hafcs_pkg::POS_W-1:0], 3'b000} +: 8] = fcs[15:8] ^ hafcs_pkg::ESC_XOR;
            end
            else
            begin
                list[{n[hafcs_pkg::POS_W-1:0], 3'b000} +: 8] = fcs[15:8];
            end
            n = n + 1'b1;
            list[{n[hafcs_pkg::POS_W-1:0], 3'b000} +: 8] = hafcs_pkg::FLAG_BYTE;
            n = n + 1'b1;
        end
    end

    always_comb
    begin
        crc_next      = crc_reg;
        in_frame_next = in_frame_reg;
        if (active)
        begin
            if (last_byte)
            begin
                crc_next      = hafcs_pkg::CRC_INIT;
                in_frame_next = 1'b0;
            end
            else
            begin
                crc_next      = crc_new;
                in_frame_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg      <= hafcs_pkg::CRC_INIT;
            in_frame_reg <= 1'b0;
        end
        else
        begin
            crc_reg      <= crc_next;
            in_frame_reg <= in_frame_next;
        end
    end

    assign load.valid     = active;
    assign load.bytes     = list;
    assign load.count     = n;
    assign load.frame_end = last_byte;

endmodule

>>> rtl/core/hafcs_serializer.sv
module hafcs_serializer (
    input  logic              clk,
    input  logic              rst_n,
    input  hafcs_pkg::load_t  load,
    output logic              can_load,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // out_byte [7:0]
    output logic              m_tlast    // frame_end
);

    logic [hafcs_pkg::LIST_W-1:0] bytes_reg;
    logic [hafcs_pkg::LIST_W-1:0] bytes_next;
    logic [hafcs_pkg::CNT_W-1:0]  cnt_reg;
    logic [hafcs_pkg::CNT_W-1:0]  cnt_next;
    logic                         end_reg;
    logic                         end_next;
    logic                         pop;

    assign pop      = m_tvalid && m_tready;
    assign can_load = (cnt_reg == '0) || ((cnt_reg == 1) && m_tready);
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = bytes_reg[7:0];
    assign m_tlast  = end_reg && (cnt_reg == 1);

    always_comb
    begin
        bytes_next = bytes_reg;
        cnt_next   = cnt_reg;
        end_next   = end_reg;
        if (load.valid)
        begin
            bytes_next = load.bytes;
            cnt_next   = load.count;
            end_next   = load.frame_end;
        end
        else if (pop)
        begin
            bytes_next = bytes_reg >> 8;
            cnt_next   = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            end_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            end_reg <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= hafcs_pkg::MAX_BEATS)
        else $error("beat count out of range");

    a_load_safe: assert property (@(posedge clk) disable iff (!rst_n)
        load.valid |-> can_load)
        else $error("load while pending beats remain");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load.valid |=> m_tvalid)
        else $error("loaded list not presented");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tlast |-> (m_tdata == hafcs_pkg::FLAG_BYTE))
        else $error("frame end not on closing flag");

endmodule

>>> rtl/core/hdlc_async_framer_fcs16.sv
// Async HDLC framer with CRC-16/X-25: each payload beat on the slave side
// becomes one to eight line bytes on the master side (opening flag, escaped
// payload, escaped FCS low byte first, closing flag marked by m_tlast). The
// master side moves one byte per cycle while m_tready is high; an item that
// produces one byte is taken every cycle while m_tready stays high, and an item
// with neither a byte nor the last mark is taken without output. s_tready is
// high while the output buffer is empty, or while it holds only its final byte
// and that byte is being taken.
module hdlc_async_framer_fcs16 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte [7:0]
    input  logic        s_tuser,   // has_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte [7:0]
    output logic        m_tlast    // frame_end
);

    hafcs_pkg::load_t load;
    logic             can_load;

    assign s_tready = can_load;

    hafcs_expand u_expand (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (s_tvalid && s_tready),
        .data_byte (s_tdata),
        .has_byte  (s_tuser),
        .last_byte (s_tlast),
        .load      (load)
    );

    hafcs_serializer u_serializer (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
